/* rtl/rc4_sector_descrambler_macros.svh */
// assertion macros for the rc4 sector descrambler
`ifndef RC4_SECTOR_DESCRAMBLER_MACROS_SVH
`define RC4_SECTOR_DESCRAMBLER_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define RC4SD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define RC4SD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rc4sd_pkg.sv */
// types, constants and helpers shared by the rc4 sector descrambler
package rc4sd_pkg;

  // sector length in bytes
  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned POS_W = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;
  localparam logic [POS_W:0] SECTOR_LEN = (POS_W + 1)'(SECTOR_BYTES);

  // permutation memory
  localparam int unsigned PERM_AW = 8;
  localparam int unsigned PERM_DW = 8;
  localparam logic [PERM_AW-1:0] PERM_LAST = '1;

  // configuration registers
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned KEY_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);
  localparam logic [KEY_W-1:0] KEY_LOW_RST  = 64'h0709_0555_0403_4E7C;
  localparam logic [KEY_W-1:0] KEY_HIGH_RST = 64'h1117_0D17_387B_2C2D;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_SWAP_RD_K,
    ST_SWAP_RD_J,
    ST_SWAP_WR_K,
    ST_SWAP_WR_J,
    ST_BYTE_X,
    ST_BYTE_Y,
    ST_BYTE_W,
    ST_BYTE_K,
    ST_BYTE_OUT
  } state_e;

  // one access request to the permutation memory
  typedef struct packed {
    logic               we;
    logic [PERM_AW-1:0] waddr;
    logic [PERM_DW-1:0] wdata;
    logic               re;
    logic [PERM_AW-1:0] raddr;
  } perm_req_t;

  // key byte n of the 16-byte key, byte 0 in the low bits of the low word
  function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] lo,
                                          input logic [KEY_W-1:0] hi,
                                          input logic [3:0] n);
    logic [KEY_W-1:0] w;
    w = n[3] ? hi : lo;
    return w[{n[2:0], 3'b000} +: 8];
  endfunction

endpackage

/* rtl/rc4_sector_descrambler.sv */
// rc4 sector descrambler top level: sequencer, key registers and output register
//
// usage
//   s_axis: one data byte per beat in s_axis_tdata_i[7:0]; each byte comes
//   back on m_axis XORed with one rc4 keystream byte, in order, one for one
//   m_axis: m_axis_tdata_o[7:0] is the result, m_axis_tlast_o marks the last
//   byte of each sector of SECTOR_BYTES bytes
//   cfg: cfg_index_i 0 writes key bytes 0..7, 1 writes key bytes 8..15,
//   other indexes are dropped; always ready, write only while idle
// timing
//   one shared 8-bit adder and a 256 x 8 permutation memory with one write
//   and one registered read port do all the work, one read and one write a cycle
//   a normal byte: three dependent reads and two writes, through the states
//   BYTE_Y, BYTE_W, BYTE_K and BYTE_OUT; the next beat is taken back in IDLE
//   the first byte of a sector first reruns the key schedule: a fill of all
//   256 entries, a swap step per entry (two reads, two writes), then one read
//   a new key takes effect at the next sector start
// reset: keys go to their reset values, the next byte starts a fresh sector
// stall: a result waits in the output register; the sequencer holds in its
//   last state until that register frees up, input ready stays low meanwhile
`include "rc4_sector_descrambler_macros.svh"

module rc4_sector_descrambler
  import rc4sd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input beats
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] data_in
  // output beats
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,   // [7:0] data_out
  output logic                 m_axis_tlast_o,   // sector_end
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [KEY_W-1:0]     cfg_data_i
);

  state_e state_q, state_d;

  logic [KEY_W-1:0]   key_lo_q, key_hi_q;
  logic [PERM_AW-1:0] cnt_q, cnt_d;      // fill and swap step counter
  logic [PERM_AW-1:0] j_q, j_d;          // swap pointer
  logic [PERM_DW-1:0] x_q, x_d;          // S[i] (or t during the schedule)
  logic [PERM_DW-1:0] y_q, y_d;          // S[j]
  logic               fwd_q, fwd_d;      // keystream address hit the last write
  logic [7:0]         data_q, data_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               rekey_q, rekey_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_data_q, out_data_d;
  logic               out_last_q, out_last_d;

  logic [POS_W:0]     pos_inc;
  logic [PERM_AW-1:0] idx;
  logic               last;
  logic               in_acc;
  logic               out_free;

  // shared adder
  logic [PERM_DW-1:0] add_a, add_b, add_c, add_sum;

  perm_req_t          req;
  logic [PERM_DW-1:0] rdata;

  rc4sd_perm_mem u_mem (
    .clk_i  (clk_i),
    .req_i  (req),
    .rdata_o(rdata)
  );

  assign pos_inc  = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
  assign idx      = PERM_AW'(pos_inc);
  assign last     = (pos_inc == SECTOR_LEN);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign add_sum  = add_a + add_b + add_c;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= KEY_LOW_RST;
      key_hi_q <= KEY_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_KEY_LOW:  key_lo_q <= cfg_data_i;
        REG_KEY_HIGH: key_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      j_q         <= '0;
      pos_q       <= '0;
      rekey_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      j_q         <= j_d;
      pos_q       <= pos_d;
      rekey_q     <= rekey_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    fwd_q      <= fwd_d;
    data_q     <= data_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    j_d         = j_q;
    x_d         = x_q;
    y_d         = y_q;
    fwd_d       = fwd_q;
    data_d      = data_q;
    pos_d       = pos_q;
    rekey_d     = rekey_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    add_a       = j_q;
    add_b       = rdata;
    add_c       = '0;
    req         = '0;

    case (state_q)
      ST_IDLE: begin
        // keep S[i] in the read register so a byte can start at once
        req.re    = 1'b1;
        req.raddr = idx;
        if (in_acc) begin
          data_d = s_axis_tdata_i;
          if (rekey_q) begin
            state_d = ST_FILL;
            cnt_d   = '0;
            j_d     = '0;
            pos_d   = '0;
            rekey_d = 1'b0;
          end else begin
            state_d = ST_BYTE_Y;
          end
        end
      end
      ST_FILL: begin
        req.we    = 1'b1;
        req.waddr = cnt_q;
        req.wdata = cnt_q;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == PERM_LAST) begin
          state_d = ST_SWAP_RD_K;
        end
      end
      ST_SWAP_RD_K: begin
        req.re    = 1'b1;
        req.raddr = cnt_q;
        state_d   = ST_SWAP_RD_J;
      end
      ST_SWAP_RD_J: begin
        // t = S[k], j += t + key[k mod 16]
        x_d       = rdata;
        add_c     = key_byte(key_lo_q, key_hi_q, cnt_q[3:0]);
        j_d       = add_sum;
        req.re    = 1'b1;
        req.raddr = add_sum;
        state_d   = ST_SWAP_WR_K;
      end
      ST_SWAP_WR_K: begin
        req.we    = 1'b1;
        req.waddr = cnt_q;
        req.wdata = rdata;
        state_d   = ST_SWAP_WR_J;
      end
      ST_SWAP_WR_J: begin
        req.we    = 1'b1;
        req.waddr = j_q;
        req.wdata = x_q;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == PERM_LAST) begin
          j_d     = '0;
          state_d = ST_BYTE_X;
        end else begin
          state_d = ST_SWAP_RD_K;
        end
      end
      ST_BYTE_X: begin
        req.re    = 1'b1;
        req.raddr = idx;
        state_d   = ST_BYTE_Y;
      end
      ST_BYTE_Y: begin
        // x = S[i], j += x
        x_d       = rdata;
        j_d       = add_sum;
        req.re    = 1'b1;
        req.raddr = add_sum;
        state_d   = ST_BYTE_W;
      end
      ST_BYTE_W: begin
        y_d       = rdata;
        req.we    = 1'b1;
        req.waddr = idx;
        req.wdata = rdata;
        state_d   = ST_BYTE_K;
      end
      ST_BYTE_K: begin
        // S[j] = x while S[x + y] is read; the read sees old data on a hit
        add_a     = x_q;
        add_b     = y_q;
        req.we    = 1'b1;
        req.waddr = j_q;
        req.wdata = x_q;
        req.re    = 1'b1;
        req.raddr = add_sum;
        fwd_d     = (add_sum == j_q);
        state_d   = ST_BYTE_OUT;
      end
      ST_BYTE_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = data_q ^ (fwd_q ? x_q : rdata);
          out_last_d  = last;
          pos_d       = last ? '0 : pos_inc[POS_W-1:0];
          rekey_d     = last;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a sector start always runs the key schedule first
  `RC4SD_ASSERT_NXT(a_rekey_start, in_acc && rekey_q, state_q == ST_FILL,
                    "sector start did not rekey")

  // the schedule hands over with the swap pointer cleared
  `RC4SD_ASSERT_NXT(a_sched_end, state_q == ST_SWAP_WR_J && cnt_q == PERM_LAST,
                    state_q == ST_BYTE_X && j_q == '0, "schedule end wrong")

  // a pending last byte leaves the block waiting for a new sector
  `RC4SD_ASSERT_IMP(a_last_rekey, out_valid_q && out_last_q && state_q == ST_IDLE,
                    rekey_q && pos_q == '0, "sector end without rekey")

  // a result is loaded exactly when the output register frees up
  `RC4SD_ASSERT_NXT(a_out_load, state_q == ST_BYTE_OUT && out_free,
                    out_valid_q && state_q == ST_IDLE, "result not loaded")

endmodule

/* rtl/rc4sd_perm_mem.sv */
// 256 x 8 permutation memory, one write and one registered read port
module rc4sd_perm_mem
  import rc4sd_pkg::*;
(
  input  logic               clk_i,
  input  perm_req_t          req_i,
  output logic [PERM_DW-1:0] rdata_o
);

  logic [PERM_DW-1:0] mem [2**PERM_AW];
  logic [PERM_DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, old data on a same-address write, holds when idle
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/tb.sv */
// testbench for the rc4 sector descrambler: byte beats checked against a keystream predictor
`timescale 1ns / 100ps

module tb;
  import rc4sd_pkg::*;

  // indexes that map to no key register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);
  localparam int unsigned DRAIN_CYCLES = 16;

  // one expected output beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i = '0;   // [7:0] data_in
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [7:0]           m_axis_tdata_o;        // [7:0] data_out
  logic                 m_axis_tlast_o;        // sector_end
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [KEY_W-1:0]     cfg_data_i = '0;

  // idle odds in percent per cycle, changed per test phase
  int unsigned src_idle_pct = 16;
  int unsigned snk_idle_pct = 62;

  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned sector_ends = 0;
  int unsigned key_writes = 0;
  int unsigned dropped_writes = 0;

  // predictor copy of key registers and rc4 state
  logic [KEY_W-1:0] key_lo = KEY_LOW_RST;
  logic [KEY_W-1:0] key_hi = KEY_HIGH_RST;
  logic [7:0]       sbox [256];
  int unsigned      sector_pos = 0;
  logic [7:0]       j_ptr = '0;
  bit               rekey_pending = 1'b1;

  out_beat_t expected_beats [$];

  rc4_sector_descrambler i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // rc4 key schedule from the current key registers
  function automatic void schedule_key();
    int         k;
    logic [7:0] j;
    logic [7:0] t;
    logic [3:0] n;
    logic [KEY_W-1:0] w;
    j = '0;
    for (k = 0; k < 256; k++) sbox[k] = 8'(k);
    for (k = 0; k < 256; k++) begin
      n = 4'(k);
      w = n[3] ? key_hi : key_lo;
      t = sbox[k];
      j = j + t + w[8 * n[2:0] +: 8];
      sbox[k] = sbox[j];
      sbox[j] = t;
    end
  endfunction

  // advance the keystream by one byte and return the expected beat
  function automatic out_beat_t descramble(input logic [7:0] din);
    out_beat_t  r;
    logic [7:0] i;
    logic [7:0] x;
    logic [7:0] y;
    if (rekey_pending) begin
      schedule_key();
      sector_pos = 0;
      j_ptr = '0;
      rekey_pending = 1'b0;
    end
    // keystream index wraps inside a long sector
    i = 8'(sector_pos + 1);
    x = sbox[i];
    j_ptr = j_ptr + x;
    y = sbox[j_ptr];
    sbox[i] = y;
    sbox[j_ptr] = x;
    sector_pos++;
    r.last = (sector_pos >= SECTOR_BYTES);
    if (r.last) begin
      sector_pos = 0;
      rekey_pending = 1'b1;
    end
    r.data = din ^ sbox[8'(x + y)];
    return r;
  endfunction

  // one input beat, entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_beats.push_back(descramble(b));
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // stop sending and wait until every expected beat is back
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
  endtask

  // one register write; hold keeps valid up for a write that follows right away
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val,
                           input bit hold);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_KEY_LOW: begin
        key_lo = val;
        key_writes++;
      end
      REG_KEY_HIGH: begin
        key_hi = val;
        key_writes++;
      end
      default: dropped_writes++;
    endcase
    @(negedge clk_i);
    if (!hold) cfg_valid_i <= 1'b0;
  endtask

  task automatic set_key(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
    wait_drained();
    cfg_write(REG_KEY_LOW, lo, 1'b1);
    cfg_write(REG_KEY_HIGH, hi, 1'b0);
  endtask

  // start of the first sector with the reset key: data extremes and walking ones
  task automatic test_data_extremes();
    int k;
    send_byte(8'h00);
    send_byte(8'hFF);
    for (k = 0; k < 8; k++) send_byte(8'(1 << k));
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h0F);
    send_byte(8'hF0);
    send_byte(8'h7F);
    send_byte(8'h80);
  endtask

  // writes to unused indexes are dropped, a new key waits for the next sector
  task automatic test_key_midsector();
    int k;
    wait_drained();
    cfg_write(REG_UNUSED_2, '1, 1'b1);
    cfg_write(REG_UNUSED_3, {$urandom, $urandom}, 1'b1);
    cfg_write(REG_KEY_LOW, '0, 1'b1);
    cfg_write(REG_KEY_HIGH, '0, 1'b0);
    for (k = 0; k < 8; k++) send_byte(8'($urandom_range(255)));
  endtask

  // random bytes under one idle setting, long enough to cross sector ends
  task automatic test_random_stream(input int unsigned n, input int unsigned src_pct,
                                    input int unsigned snk_pct);
    int unsigned k;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (k = 0; k < n; k++) send_byte(8'($urandom_range(255)));
  endtask

  // random key with a dropped write mixed in
  task automatic test_random_key();
    wait_drained();
    cfg_write(REG_KEY_HIGH, {$urandom, $urandom}, 1'b1);
    cfg_write(REG_UNUSED_3, {$urandom, $urandom}, 1'b1);
    cfg_write(REG_KEY_LOW, {$urandom, $urandom}, 1'b0);
  endtask

  // receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  // output beat checker
  always @(posedge clk_i) begin : check_beat
    out_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat data %02h last %0b", $time, m_axis_tdata_o,
                 m_axis_tlast_o);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (m_axis_tdata_o !== want.data) begin
          $display("%0t: data_out expected %02h actual %02h", $time, want.data,
                   m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $display("%0t: sector_end expected %0b actual %0b", $time, want.last,
                   m_axis_tlast_o);
          errors++;
        end
        if (m_axis_tlast_o === 1'b1) sector_ends++;
      end
    end
  end

  initial begin
    int k;
    for (k = 0; k < 256; k++) sbox[k] = 8'(k);
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_data_extremes();
    test_key_midsector();
    // zero key takes over at the second sector
    test_random_stream(520, 16, 62);
    set_key('1, '1);
    // all-ones key takes over at the third sector
    test_random_stream(500, 62, 16);
    test_random_key();
    test_random_stream(520, 0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("%0d bytes checked across %0d sector ends", bytes_sent, sector_ends);
    $display("%0d key register writes, %0d writes to unused indexes dropped",
             key_writes, dropped_writes);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
